// ----- rtl/saw_arq_pkg.sv -----
// saw_arq_pkg: shared types, codes and sizes for the stop-and-wait link controller
// used by saw_arq_core, saw_arq_fifo and the top level; no dependencies
package saw_arq_pkg;

  localparam int SeqBits   = 8;
  localparam int ResDepth  = 4;
  localparam int ResPtrW   = $clog2(ResDepth);
  localparam int ResCntW   = $clog2(ResDepth + 1);
  localparam int InWidth   = 64;
  localparam int OutWidth  = 32;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam logic [15:0] TxTimeoutRst   = 16'd5000;
  localparam logic [15:0] ReplyWindowRst = 16'd1000;

  typedef enum logic [1:0] {
    MODE_SEND   = 2'd0,
    MODE_TXDONE = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_RX     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_NEW     = 3'd1,
    ACT_RESEND  = 3'd2,
    ACT_ACK     = 3'd3,
    ACT_DELIVER = 3'd4,
    ACT_GAVEUP  = 3'd5,
    ACT_BUSY    = 3'd6,
    ACT_TXFAIL  = 3'd7
  } act_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEVICE_ID    = 3'd0,
    REG_PROTO_VER    = 3'd1,
    REG_MAX_RETRIES  = 3'd2,
    REG_TX_TIMEOUT   = 3'd3,
    REG_REPLY_WINDOW = 3'd4,
    REG_MIN_SIZE     = 3'd5,
    REG_CMD_TYPE     = 3'd6,
    REG_ACK_CMD      = 3'd7
  } reg_idx_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] frame_size;
    logic [7:0] frame_version;
    logic [7:0] frame_dest;
    logic [7:0] frame_src;
    logic [7:0] frame_type;
    logic [7:0] frame_command;
    logic [7:0] frame_seq;
  } item_t;

  typedef struct packed {
    act_e       action;
    logic [7:0] seq_out;
    logic [7:0] ack_dest;
    logic [7:0] ack_payload;
    logic [1:0] phase_out;
    logic       last;
  } result_t;

  // one or two results caused by one request
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } res_pair_t;

  function automatic logic [7:0] seq_byte(logic [SeqBits-1:0] s);
    logic [15:0] w;
    w = 16'(s);
    return w[7:0];
  endfunction

endpackage

// ----- rtl/saw_arq_core.sv -----
// saw_arq_core: link phase machine, sequence and retry counters, config registers
// depends on saw_arq_pkg
module saw_arq_core import saw_arq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                accept_i,
  input  item_t               item_i,
  output res_pair_t           res_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TX   = 2'd1,
    PH_WAIT = 2'd2
  } phase_e;

  logic [7:0]  device_id_q, proto_ver_q, min_size_q, cmd_type_q, ack_cmd_q;
  logic [3:0]  max_retries_q;
  logic [15:0] tx_timeout_q, reply_window_q;

  phase_e             phase_q, phase_d;
  logic [SeqBits-1:0] next_seq_q, next_seq_d, stored_seq_q, stored_seq_d;
  logic [3:0]         retry_q, retry_d, retry_inc;
  logic               sent_ack_q, sent_ack_d;
  logic [15:0]        wait_q, wait_d;
  logic [16:0]        tick_inc;
  logic               rx_ok, is_cmd;
  res_pair_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q    <= 8'd0;
      proto_ver_q    <= 8'd1;
      max_retries_q  <= 4'd3;
      tx_timeout_q   <= TxTimeoutRst;
      reply_window_q <= ReplyWindowRst;
      min_size_q     <= 8'd4;
      cmd_type_q     <= 8'd1;
      ack_cmd_q      <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DEVICE_ID:    device_id_q    <= cfg_wdata_i[7:0];
        REG_PROTO_VER:    proto_ver_q    <= cfg_wdata_i[7:0];
        REG_MAX_RETRIES:  max_retries_q  <= cfg_wdata_i[3:0];
        REG_TX_TIMEOUT:   tx_timeout_q   <= cfg_wdata_i;
        REG_REPLY_WINDOW: reply_window_q <= cfg_wdata_i;
        REG_MIN_SIZE:     min_size_q     <= cfg_wdata_i[7:0];
        REG_CMD_TYPE:     cmd_type_q     <= cfg_wdata_i[7:0];
        REG_ACK_CMD:      ack_cmd_q      <= cfg_wdata_i[7:0];
        default:          ;
      endcase
    end
  end

  assign tick_inc  = {1'b0, wait_q} + 17'd1;
  assign retry_inc = retry_q + 4'd1;
  assign is_cmd    = (item_i.frame_type == cmd_type_q);
  assign rx_ok     = (phase_q == PH_WAIT) && (item_i.frame_size >= min_size_q) &&
                     (item_i.frame_version == proto_ver_q) &&
                     (item_i.frame_dest == device_id_q);

  always_comb begin
    phase_d      = phase_q;
    next_seq_d   = next_seq_q;
    stored_seq_d = stored_seq_q;
    retry_d      = retry_q;
    sent_ack_d   = sent_ack_q;
    wait_d       = wait_q;
    res          = '0;
    res.first.action  = ACT_NONE;
    res.second.action = ACT_NONE;

    unique case (item_i.mode)
      MODE_SEND: begin
        if (phase_q == PH_IDLE) begin
          retry_d            = 4'd0;
          stored_seq_d       = next_seq_q;
          next_seq_d         = next_seq_q + SeqBits'(1);
          sent_ack_d         = is_cmd && (item_i.frame_command == ack_cmd_q);
          phase_d            = PH_TX;
          wait_d             = 16'd0;
          res.first.action   = ACT_NEW;
          res.first.seq_out  = seq_byte(next_seq_q);
        end else begin
          res.first.action   = ACT_BUSY;
        end
      end
      MODE_TXDONE: begin
        if (phase_q == PH_TX) begin
          phase_d = sent_ack_q ? PH_IDLE : PH_WAIT;
          wait_d  = 16'd0;
        end
      end
      MODE_TICK: begin
        if (phase_q == PH_TX) begin
          if (tick_inc >= {1'b0, tx_timeout_q}) begin
            phase_d          = PH_IDLE;
            wait_d           = 16'd0;
            res.first.action = ACT_TXFAIL;
          end else begin
            wait_d = tick_inc[15:0];
          end
        end else if (phase_q == PH_WAIT) begin
          if (tick_inc >= {1'b0, reply_window_q}) begin
            retry_d = retry_inc;
            wait_d  = 16'd0;
            if (retry_inc >= max_retries_q) begin
              phase_d          = PH_IDLE;
              res.first.action = ACT_GAVEUP;
            end else begin
              phase_d           = PH_TX;
              sent_ack_d        = 1'b0;
              res.first.action  = ACT_RESEND;
              res.first.seq_out = seq_byte(stored_seq_q);
            end
          end else begin
            wait_d = tick_inc[15:0];
          end
        end
      end
      MODE_RX: begin
        if (rx_ok) begin
          res.first.action = ACT_DELIVER;
          if (is_cmd) begin
            phase_d = PH_IDLE;
            wait_d  = 16'd0;
          end
          // pure acks are not answered
          if (!(is_cmd && (item_i.frame_command == ack_cmd_q))) begin
            next_seq_d             = next_seq_q + SeqBits'(1);
            sent_ack_d             = 1'b1;
            phase_d                = PH_TX;
            wait_d                 = 16'd0;
            res.two                = 1'b1;
            res.second.action      = ACT_ACK;
            res.second.seq_out     = seq_byte(next_seq_q);
            res.second.ack_dest    = item_i.frame_src;
            res.second.ack_payload = item_i.frame_seq;
          end
        end
      end
      default: ;
    endcase

    res.first.phase_out  = phase_d;
    res.second.phase_out = phase_d;
    res.first.last       = !res.two;
    res.second.last      = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      next_seq_q   <= '0;
      stored_seq_q <= '0;
      retry_q      <= 4'd0;
      sent_ack_q   <= 1'b0;
      wait_q       <= 16'd0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      next_seq_q   <= next_seq_d;
      stored_seq_q <= stored_seq_d;
      retry_q      <= retry_d;
      sent_ack_q   <= sent_ack_d;
      wait_q       <= wait_d;
    end
  end

  assign res_o = res;

endmodule

// ----- rtl/saw_arq_fifo.sv -----
// saw_arq_fifo: small result queue, takes one or two results per push, pops one
// depends on saw_arq_pkg
module saw_arq_fifo import saw_arq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  res_pair_t res_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output result_t   data_o
);

  result_t            mem_q [ResDepth];
  logic [ResPtrW-1:0] wr_q, rd_q;
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic               pop;
  logic [ResCntW-1:0] n_push;

  assign pop     = valid_o && ready_i;
  assign n_push  = push_i ? (res_i.two ? ResCntW'(2) : ResCntW'(1)) : '0;
  assign cnt_d   = cnt_q + n_push - ResCntW'(pop);
  // room for a worst-case pair
  assign room_o  = (cnt_q <= ResCntW'(ResDepth - 2));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= res_i.first;
      if (res_i.two) begin
        mem_q[wr_q + ResPtrW'(1)] <= res_i.second;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + ResPtrW'(n_push);
      end
      if (pop) begin
        rd_q <= rd_q + ResPtrW'(1);
      end
    end
  end

endmodule

// ----- rtl/stop_and_wait_arq_link_fsm_unit.sv -----
// stop_and_wait_arq_link_fsm_unit: top level of the stop-and-wait link controller
// depends on saw_arq_pkg, saw_arq_core, saw_arq_fifo
//
// usage
// - slave stream carries one event request per beat: send request, transmit
//   done, millisecond tick or received frame header
// - master stream returns one or two results per request; tlast marks the
//   final one (a delivered frame that needs an answer gives deliver, then ack)
// - config port: write cfg_we_i with cfg_idx_i / cfg_wdata_i while idle
// - results are registered: a request's results enter the queue on its accept edge
// - throughput: one request per cycle while each gives one result and the
//   master side is ready; a two-result request gives its results one after another
// - the phase machine updates in the accept cycle, results go to a four entry
//   queue; s_axis_tready drops while fewer than two slots are free
// - when the receiver stalls, queued results hold; from an empty queue three
//   one-result requests (or two two-result ones) are taken before the slave
//   side back-pressures
// - reset (async, active low) gives idle phase, zero counters, register
//   defaults and an empty queue
module stop_and_wait_arq_link_fsm_unit import saw_arq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // event requests
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // from bit 0: mode[1:0], frame_size[9:2], frame_version[17:10],
  // frame_dest[25:18], frame_src[33:26], frame_type[41:34],
  // frame_command[49:42], frame_seq[57:50], zero pad[63:58]
  input  logic [InWidth-1:0]  s_axis_tdata,
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // from bit 0: action[2:0], seq_out[10:3], ack_dest[18:11],
  // ack_payload[26:19], phase_out[28:27], zero pad[31:29]
  output logic [OutWidth-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  item_t     item;
  res_pair_t res;
  result_t   head;
  logic      accept;
  logic      room;

  // unpack the request word
  assign item.mode          = mode_e'(s_axis_tdata[1:0]);
  assign item.frame_size    = s_axis_tdata[9:2];
  assign item.frame_version = s_axis_tdata[17:10];
  assign item.frame_dest    = s_axis_tdata[25:18];
  assign item.frame_src     = s_axis_tdata[33:26];
  assign item.frame_type    = s_axis_tdata[41:34];
  assign item.frame_command = s_axis_tdata[49:42];
  assign item.frame_seq     = s_axis_tdata[57:50];

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  saw_arq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (item),
    .res_o       (res)
  );

  saw_arq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .res_i   (res),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (head)
  );

  // pack the result word
  assign m_axis_tdata = {3'b000, head.phase_out, head.ack_payload, head.ack_dest,
                         head.seq_out, head.action};
  assign m_axis_tlast = head.last;

endmodule

// ----- rtl/saw_arq_checker.sv -----
// saw_arq_checker: port-level assertions for the stop-and-wait link controller
// bound to stop_and_wait_arq_link_fsm_unit; depends on saw_arq_pkg
module saw_arq_checker import saw_arq_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutWidth-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // only a deliver result can be followed by another result of the same request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] != ACT_DELIVER) |-> m_axis_tlast)
    else $error("non-deliver result without last");

  // sequence field only set for new, resend and ack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] != ACT_NEW) && (m_axis_tdata[2:0] != ACT_RESEND) &&
    (m_axis_tdata[2:0] != ACT_ACK) |-> (m_axis_tdata[10:3] == 8'd0))
    else $error("sequence field set on non-send result");

  // phase code in range and padding clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[28:27] != 2'd3) && (m_axis_tdata[31:29] == 3'd0))
    else $error("bad phase code or padding");

endmodule

bind stop_and_wait_arq_link_fsm_unit saw_arq_checker u_saw_arq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- test/testbench.sv -----
// testbench for stop_and_wait_arq_link_fsm_unit: directed and random event requests,
// with results checked against a built-in model of the link phase machine
// depends on saw_arq_pkg and the rtl of the block only
`timescale 1ns / 1ps

module testbench;
  import saw_arq_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 6;

  // phase codes of the link machine
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TX   = 2'd1,
    PH_WAIT = 2'd2
  } link_phase_e;

  // tracks the link state, predicts results per request and checks them in order
  class arq_tracker;
    // register copies
    logic [7:0]  dev_id = 8'd0;
    logic [7:0]  proto_ver = 8'd1;
    logic [3:0]  retry_limit = 4'd3;
    logic [15:0] tx_limit = TxTimeoutRst;
    logic [15:0] window_limit = ReplyWindowRst;
    logic [7:0]  min_size = 8'd4;
    logic [7:0]  cmd_type = 8'd1;
    logic [7:0]  ack_cmd = 8'd0;
    // link state
    link_phase_e phase = PH_IDLE;
    logic [7:0]  next_seq = 8'd0;
    logic [7:0]  held_seq = 8'd0;
    logic [3:0]  retries = 4'd0;
    logic        sent_ack = 1'b0;
    logic [15:0] ticks = 16'd0;
    result_t     pending_actions[$];
    int          errors = 0;

    function void set_reg(reg_idx_e idx, logic [15:0] v);
      case (idx)
        REG_DEVICE_ID:    dev_id = v[7:0];
        REG_PROTO_VER:    proto_ver = v[7:0];
        REG_MAX_RETRIES:  retry_limit = v[3:0];
        REG_TX_TIMEOUT:   tx_limit = v;
        REG_REPLY_WINDOW: window_limit = v;
        REG_MIN_SIZE:     min_size = v[7:0];
        REG_CMD_TYPE:     cmd_type = v[7:0];
        REG_ACK_CMD:      ack_cmd = v[7:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] claim_seq();
      logic [7:0] s;
      s = next_seq;
      next_seq = next_seq + 8'd1;
      return s;
    endfunction

    // accepted request: advance the link state and queue its one or two results
    function void note_request(item_t it);
      result_t head;
      result_t tail;
      logic two;
      logic [16:0] t;
      head = '0;
      tail = '0;
      two = 1'b0;
      head.action = ACT_NONE;
      t = {1'b0, ticks} + 17'd1;
      case (it.mode)
        MODE_SEND: begin
          if (phase == PH_IDLE) begin
            retries = 4'd0;
            held_seq = claim_seq();
            sent_ack = (it.frame_type == cmd_type) && (it.frame_command == ack_cmd);
            phase = PH_TX;
            ticks = 16'd0;
            head.action = ACT_NEW;
            head.seq_out = held_seq;
          end else begin
            // refused, state untouched
            head.action = ACT_BUSY;
          end
        end
        MODE_TXDONE: begin
          if (phase == PH_TX) begin
            phase = sent_ack ? PH_IDLE : PH_WAIT;
            ticks = 16'd0;
          end
        end
        MODE_TICK: begin
          if (phase == PH_TX) begin
            if (t >= {1'b0, tx_limit}) begin
              phase = PH_IDLE;
              ticks = 16'd0;
              head.action = ACT_TXFAIL;
            end else begin
              ticks = t[15:0];
            end
          end else if (phase == PH_WAIT) begin
            if (t >= {1'b0, window_limit}) begin
              retries = retries + 4'd1;
              ticks = 16'd0;
              if (retries >= retry_limit) begin
                phase = PH_IDLE;
                head.action = ACT_GAVEUP;
              end else begin
                phase = PH_TX;
                sent_ack = 1'b0;
                head.action = ACT_RESEND;
                head.seq_out = held_seq;
              end
            end else begin
              ticks = t[15:0];
            end
          end
        end
        MODE_RX: begin
          if (phase == PH_WAIT && it.frame_size >= min_size &&
              it.frame_version == proto_ver && it.frame_dest == dev_id) begin
            head.action = ACT_DELIVER;
            two = 1'b1;
            // a command frame ends the wait, a pure ack needs no answer
            if (it.frame_type == cmd_type) begin
              phase = PH_IDLE;
              ticks = 16'd0;
              if (it.frame_command == ack_cmd) two = 1'b0;
            end
            if (two) begin
              tail.action = ACT_ACK;
              tail.seq_out = claim_seq();
              tail.ack_dest = it.frame_src;
              tail.ack_payload = it.frame_seq;
              sent_ack = 1'b1;
              phase = PH_TX;
              ticks = 16'd0;
            end
          end
        end
        default: ;
      endcase
      head.phase_out = phase;
      tail.phase_out = phase;
      head.last = !two;
      tail.last = 1'b1;
      pending_actions.push_back(head);
      if (two) pending_actions.push_back(tail);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_actions.size() == 0) begin
        $display("%0t: result with none pending: act=%0d seq=%0h dst=%0h pay=%0h ph=%0d last=%0b",
                 $time, got.action, got.seq_out, got.ack_dest, got.ack_payload,
                 got.phase_out, got.last);
        errors++;
        return;
      end
      want = pending_actions.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected act=%0d seq=%0h dst=%0h pay=%0h ph=%0d last=%0b",
                 $time, want.action, want.seq_out, want.ack_dest, want.ack_payload,
                 want.phase_out, want.last);
        $display("%0t:          actual   act=%0d seq=%0h dst=%0h pay=%0h ph=%0d last=%0b",
                 $time, got.action, got.seq_out, got.ack_dest, got.ack_payload,
                 got.phase_out, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InWidth-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutWidth-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  arq_tracker sb = new();
  // random gaps and stalls on both sides while set
  bit idle_on = 1'b1;

  stop_and_wait_arq_link_fsm_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("[stop_and_wait_arq_link_fsm_unit] ERROR");
        $finish;
      end
    end
  end

  // receiver: random mix of ready runs and stall bursts
  initial begin
    int run;
    bit hold;
    run = 0;
    hold = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (run == 0) begin
        hold = ($urandom_range(0, 2) == 0);
        run = hold ? $urandom_range(1, 14) : $urandom_range(1, 40);
      end
      run--;
      m_axis_tready <= !(hold && idle_on);
    end
  end

  // result monitor, samples pre-edge values
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.action      = act_e'(m_axis_tdata[2:0]);
      got.seq_out     = m_axis_tdata[10:3];
      got.ack_dest    = m_axis_tdata[18:11];
      got.ack_payload = m_axis_tdata[26:19];
      got.phase_out   = m_axis_tdata[28:27];
      got.last        = m_axis_tlast;
      sb.check_result(got);
    end
  end

  function automatic item_t mk(mode_e m, logic [7:0] sz, logic [7:0] ver, logic [7:0] dst,
                               logic [7:0] src, logic [7:0] ty, logic [7:0] cmd,
                               logic [7:0] sq);
    item_t it;
    it.mode = m;
    it.frame_size = sz;
    it.frame_version = ver;
    it.frame_dest = dst;
    it.frame_src = src;
    it.frame_type = ty;
    it.frame_command = cmd;
    it.frame_seq = sq;
    return it;
  endfunction

  // random event shaped by the current phase so that the machine walks its full cycle
  function automatic item_t next_event();
    item_t it;
    int pick;
    it = mk(mode_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom),
            8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    // plain noise
    if ($urandom_range(0, 99) < 12) return it;
    pick = $urandom_range(0, 99);
    case (sb.phase)
      PH_IDLE: it.mode = (pick < 75) ? MODE_SEND : mode_e'($urandom_range(1, 3));
      PH_TX:   it.mode = (pick < 45) ? MODE_TXDONE : (pick < 85) ? MODE_TICK :
                         (pick < 92) ? MODE_SEND : MODE_RX;
      default: it.mode = (pick < 40) ? MODE_TICK : (pick < 90) ? MODE_RX :
                         (pick < 95) ? MODE_TXDONE : MODE_SEND;
    endcase
    // some sends are pure acks
    if (it.mode == MODE_SEND && $urandom_range(0, 2) == 0) begin
      it.frame_type = sb.cmd_type;
      it.frame_command = sb.ack_cmd;
    end
    // most received frames pass the filters, half are commands, half of those acks
    if (it.mode == MODE_RX && $urandom_range(0, 3) != 0) begin
      it.frame_size = 8'($urandom_range(sb.min_size, 255));
      it.frame_version = sb.proto_ver;
      it.frame_dest = sb.dev_id;
      if ($urandom_range(0, 1) == 1) it.frame_type = sb.cmd_type;
      if ($urandom_range(0, 1) == 1) it.frame_command = sb.ack_cmd;
    end
    return it;
  endfunction

  // offer one request, optionally after a gap, and note it once accepted
  task automatic issue(item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, it.frame_seq, it.frame_command, it.frame_type, it.frame_src,
                     it.frame_dest, it.frame_version, it.frame_size, it.mode};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(it);
  endtask

  // stop offering, wait for every pending result, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_actions.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_link(logic [7:0] dev, logic [7:0] ver, logic [3:0] retry,
                              logic [15:0] txto, logic [15:0] window, logic [7:0] min_len,
                              logic [7:0] cmd, logic [7:0] ack);
    logic [15:0] vals [8];
    settle();
    vals[0] = 16'(dev);
    vals[1] = 16'(ver);
    vals[2] = 16'(retry);
    vals[3] = txto;
    vals[4] = window;
    vals[5] = 16'(min_len);
    vals[6] = 16'(cmd);
    vals[7] = 16'(ack);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= reg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      sb.set_reg(reg_idx_e'(i), vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_DEVICE_ID;
    cfg_wdata_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: events that do nothing while idle
    issue(mk(MODE_TXDONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(mk(MODE_RX, 8'h04, 8'h01, 8'h00, 8'h12, 8'h02, 8'h03, 8'h44));

    // short windows so every timeout is reachable
    program_link(8'h5A, 8'h01, 4'd2, 16'd3, 16'd2, 8'd4, 8'h01, 8'h00);
    // fresh data frame, busy refusal, reply window opened
    issue(mk(MODE_SEND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h07, 8'h00));
    issue(mk(MODE_SEND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h07, 8'h00));
    issue(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(mk(MODE_TXDONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // frames failing length, version and destination checks
    issue(mk(MODE_RX, 8'h03, 8'h01, 8'h5A, 8'h11, 8'h02, 8'h05, 8'h21));
    issue(mk(MODE_RX, 8'h10, 8'h02, 8'h5A, 8'h11, 8'h02, 8'h05, 8'h21));
    issue(mk(MODE_RX, 8'h10, 8'h01, 8'h5B, 8'h11, 8'h02, 8'h05, 8'h21));
    // window expiry: resend, then give up
    issue(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(mk(MODE_TXDONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // pure ack sent: transmit done goes straight back to idle
    issue(mk(MODE_SEND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00));
    issue(mk(MODE_TXDONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // transmit never done
    issue(mk(MODE_SEND, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    issue(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // data frame received with all-ones size, source, type, command and sequence: deliver and answer, then ack done
    issue(mk(MODE_SEND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(mk(MODE_TXDONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(mk(MODE_RX, 8'hFF, 8'h01, 8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    issue(mk(MODE_TXDONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // ack command received: deliver only, wait ends
    issue(mk(MODE_SEND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00));
    issue(mk(MODE_TXDONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(mk(MODE_RX, 8'h04, 8'h01, 8'h5A, 8'h00, 8'h01, 8'h00, 8'h00));

    // random phases, each under its own register setting
    for (int p = 0; p < 8; p++) begin
      case (p)
        // all-zero registers, limits expire on the first tick
        1: program_link(8'h00, 8'h00, 4'd0, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00);
        // all-ones bytes, most retries, limits of one tick
        2: program_link(8'hFF, 8'hFF, 4'd15, 16'd1, 16'd1, 8'hFF, 8'hFF, 8'hFF);
        // longest limits
        3: program_link(8'($urandom), 8'($urandom), 4'd15, 16'hFFFF, 16'hFFFF,
                        8'($urandom_range(0, 30)), 8'($urandom_range(0, 3)),
                        8'($urandom_range(0, 3)));
        default: program_link(8'($urandom), 8'($urandom), 4'($urandom_range(1, 4)),
                              16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                              8'($urandom_range(0, 24)), 8'($urandom_range(0, 3)),
                              8'($urandom_range(0, 3)));
      endcase
      // last phase runs without gaps or stalls
      idle_on = (p != 7);
      repeat ((p == 3) ? 40 : 110) issue(next_event());
    end

    settle();
    if (sb.pending_actions.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending_actions.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[stop_and_wait_arq_link_fsm_unit] OK");
    end else begin
      $display("[stop_and_wait_arq_link_fsm_unit] ERROR");
    end
    $finish;
  end

endmodule
